### sv/rps_pkg.sv
// rps_pkg: shared types and constants for the report packet segmenter.
// No dependencies; imported by every module of the block.
package rps_pkg;

  localparam int MAX_MESSAGE_BYTES = 65536;
  localparam int LEN_W             = 17;
  localparam int QDEPTH            = 4;
  localparam int QPTR_W            = $clog2(QDEPTH);
  localparam int QCNT_W            = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MAX_MESSAGE_BYTES);
  localparam logic [LEN_W-1:0] FIRST_LIMIT = LEN_W'(60);
  localparam logic [LEN_W-1:0] CONT_LIMIT  = LEN_W'(61);
  localparam logic [5:0]       FULL_PKT    = 6'd61;

  localparam logic [1:0] TYPE_FIRST = 2'b00;
  localparam logic [1:0] TYPE_CONT  = 2'b01;
  localparam logic [1:0] TYPE_LAST  = 2'b11;

  localparam logic [1:0] KIND_COMP  = 2'd0;
  localparam logic [1:0] KIND_HDR   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_CKSUM = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       open;
    logic [7:0] hdr;
    logic       close;
    logic [7:0] sum;
    logic       done;
  } rps_entry_t;

endpackage

### sv/rps_front.sv
// rps_front: accepts message bytes, tracks packet framing and classifies
// each byte into a queue entry. Depends on rps_pkg.
module rps_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic [7:0]               in_data_byte,
  input  logic [rps_pkg::LEN_W-1:0] in_message_length,
  input  logic                     q_full,
  output logic                     q_push,
  output rps_pkg::rps_entry_t      q_entry
);
  import rps_pkg::*;

  logic             in_msg_r, in_msg_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] sent_r, sent_nxt;
  logic [5:0]       psize_r, psize_nxt;
  logic [5:0]       ppos_r, ppos_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic             accept, drop, open, close, done;
  logic [LEN_W-1:0] len_clamped, ll, bs, rem, bs_inc;
  logic [5:0]       pos, sz, size_eff, pos_inc;
  logic [7:0]       hdr, sum_base, sum_new;
  logic [1:0]       ptype;

  always_comb begin
    accept      = in_push && !q_full;
    len_clamped = (in_message_length > MAX_LEN) ? MAX_LEN : in_message_length;
    drop        = !in_msg_r && (len_clamped == '0);
    ll          = in_msg_r ? len_r  : len_clamped;
    bs          = in_msg_r ? sent_r : '0;
    pos         = in_msg_r ? ppos_r : '0;
    open        = (pos == 6'd0);
    rem         = ll - bs;
    sz          = (rem > FIRST_LIMIT) ? FULL_PKT : rem[5:0];
    priority if (ll > FIRST_LIMIT && bs == '0) begin
      ptype = TYPE_FIRST;
    end else if (rem > CONT_LIMIT && bs != '0) begin
      ptype = TYPE_CONT;
    end else begin
      ptype = TYPE_LAST;
    end
    hdr      = {ptype, sz};
    size_eff = open ? sz : psize_r;
    sum_base = (open || !in_msg_r) ? 8'd0 : sum_r;
    sum_new  = sum_base + in_data_byte;
    pos_inc  = pos + 6'd1;
    bs_inc   = bs + LEN_W'(1);
    close    = (pos_inc >= size_eff);
    done     = close && (bs_inc >= ll);

    in_msg_nxt = in_msg_r;
    len_nxt    = len_r;
    sent_nxt   = sent_r;
    psize_nxt  = psize_r;
    ppos_nxt   = ppos_r;
    sum_nxt    = sum_r;
    if (accept && !drop) begin
      in_msg_nxt = !done;
      len_nxt    = ll;
      sent_nxt   = bs_inc;
      psize_nxt  = size_eff;
      ppos_nxt   = close ? 6'd0 : pos_inc;
      sum_nxt    = sum_new;
    end

    q_push        = accept && !drop;
    q_entry.data  = in_data_byte;
    q_entry.open  = open;
    q_entry.hdr   = hdr;
    q_entry.close = close;
    q_entry.sum   = sum_new;
    q_entry.done  = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= '0;
      sent_r   <= '0;
      psize_r  <= '0;
      ppos_r   <= '0;
      sum_r    <= '0;
    end else begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
      sent_r   <= sent_nxt;
      psize_r  <= psize_nxt;
      ppos_r   <= ppos_nxt;
      sum_r    <= sum_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_msg_r |-> (ppos_r < psize_r || ppos_r == 6'd0))
    else $error("packet position beyond packet size");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_entry.done |-> q_entry.close)
    else $error("message finished without closing a packet");

endmodule

### sv/rps_queue.sv
// rps_queue: short entry queue between front and back.
// Depends on rps_pkg.
module rps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rps_pkg::rps_entry_t wr_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output rps_pkg::rps_entry_t rd_entry
);
  import rps_pkg::*;

  rps_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    full     = (cnt_r == QCNT_W'(QDEPTH));
    empty    = (cnt_r == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    cnt_nxt  = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    rd_entry = mem_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != QCNT_W'(QDEPTH)) |-> (wptr_r - rptr_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !do_pop |=> !empty)
    else $error("queue lost an entry");

endmodule

### sv/rps_back.sv
// rps_back: expands queue entries into stream bytes in an output register,
// one per cycle while that register is empty or popped. Depends on rps_pkg.
module rps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rps_pkg::rps_entry_t q_entry,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_byte_kind,
  output logic                out_message_done,
  output logic                out_run_last
);
  import rps_pkg::*;

  rps_entry_t cur_r, cur_nxt;
  logic       cur_vld_r, cur_vld_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       ovld_r, ovld_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic [1:0] okind_r, okind_nxt;
  logic       odone_r, odone_nxt;
  logic       olast_r, olast_nxt;
  logic       slot_free, emit, last, load;

  always_comb begin
    slot_free = !ovld_r || out_pop;
    emit      = cur_vld_r && slot_free;
    last      = (phase_r == KIND_CKSUM) || (phase_r == KIND_DATA && !cur_r.close);
    load      = !q_empty && (!cur_vld_r || (emit && last));
    q_pop     = load;

    ovld_nxt  = ovld_r && !out_pop;
    obyte_nxt = obyte_r;
    okind_nxt = okind_r;
    odone_nxt = odone_r;
    olast_nxt = olast_r;
    if (emit) begin
      ovld_nxt  = 1'b1;
      okind_nxt = phase_r;
      odone_nxt = (phase_r == KIND_CKSUM) && cur_r.done;
      olast_nxt = last;
      unique case (phase_r)
        KIND_COMP: obyte_nxt = 8'(9'h100 - {1'b0, cur_r.hdr});
        KIND_HDR:  obyte_nxt = cur_r.hdr;
        KIND_DATA: obyte_nxt = cur_r.data;
        default:   obyte_nxt = cur_r.sum;
      endcase
    end

    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    phase_nxt   = phase_r;
    if (load) begin
      cur_nxt     = q_entry;
      cur_vld_nxt = 1'b1;
      phase_nxt   = q_entry.open ? KIND_COMP : KIND_DATA;
    end else if (emit) begin
      if (last) begin
        cur_vld_nxt = 1'b0;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end

    out_empty        = !ovld_r;
    out_byte         = obyte_r;
    out_byte_kind    = okind_r;
    out_message_done = odone_r;
    out_run_last     = olast_r;
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    okind_r <= okind_nxt;
    odone_r <= odone_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      phase_r   <= KIND_COMP;
      ovld_r    <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      phase_r   <= phase_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && odone_r |-> (okind_r == KIND_CKSUM) && olast_r)
    else $error("message done off a closing checksum");
  assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r && (phase_r == KIND_COMP || phase_r == KIND_HDR) |-> cur_r.open)
    else $error("framing phase on an entry that opens no packet");
  assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && (okind_r == KIND_COMP || okind_r == KIND_HDR) |-> !olast_r)
    else $error("item run ended on a framing byte");

endmodule

### sv/report_packet_segmenter.sv
// report_packet_segmenter: top level; front classifier, entry queue and
// byte emitter. Depends on rps_pkg, rps_front, rps_queue and rps_back.
//
// Takes one message byte per item and returns its framed stream bytes:
// complement and header when a packet opens, the payload byte, and the
// checksum when a packet closes, so one item gives 1 to 4 results. The
// front accepts an item every cycle while its four-entry queue has room;
// the back emits one result per cycle into an output register while that
// register is empty or being popped, about 64 results per 61 bytes on
// long messages. A message length of zero on a message's first byte drops
// that item with no result.
module report_packet_segmenter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_data_byte,
  input  logic [rps_pkg::LEN_W-1:0] in_message_length,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_byte,
  output logic [1:0]                out_byte_kind,
  output logic                      out_message_done,
  output logic                      out_run_last
);
  import rps_pkg::*;

  rps_entry_t wr_entry, rd_entry;
  logic       q_push, q_full, q_pop, q_empty;

  assign in_full = q_full;

  rps_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_data_byte      (in_data_byte),
    .in_message_length (in_message_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (wr_entry)
  );

  rps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (rd_entry)
  );

  rps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_entry          (rd_entry),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_byte_kind    (out_byte_kind),
    .out_message_done (out_message_done),
    .out_run_last     (out_run_last)
  );

endmodule

### test/report_packet_segmenter_test.sv
`timescale 1ns / 100ps
// report_packet_segmenter_test: self-checking bench for the packet segmenter.
// Predicts the framed byte stream of every accepted item and checks each
// popped result against it. Depends on rps_pkg and report_packet_segmenter.
module report_packet_segmenter_test;
  import rps_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic [1:0] kind;
    logic       done;
    logic       last;
  } stream_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [7:0]       in_data_byte = 8'h00;
  logic [LEN_W-1:0] in_message_length = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [7:0]       out_byte;
  logic [1:0]       out_byte_kind;
  logic             out_message_done;
  logic             out_run_last;

  // segmenter state as predicted
  logic [LEN_W-1:0] msg_len;
  logic [LEN_W-1:0] sent;
  logic [5:0]       pkt_size;
  logic [5:0]       pkt_pos;
  logic [7:0]       pkt_sum;
  bit               busy;

  stream_byte_t expected_bytes[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int mismatches = 0;
  int checked = 0;
  int payload_items = 0;
  int dropped_items = 0;
  int messages = 0;

  report_packet_segmenter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_message_length (in_message_length),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_byte_kind     (out_byte_kind),
    .out_message_done  (out_message_done),
    .out_run_last      (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d bytes outstanding", expected_bytes.size());
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t: %s", $time, what);
  endtask

  function automatic void clear_segmenter();
    msg_len = '0;
    sent = '0;
    pkt_size = '0;
    pkt_pos = '0;
    pkt_sum = '0;
    busy = 1'b0;
  endfunction

  function automatic void segment_byte(input logic [7:0] d, input logic [LEN_W-1:0] len);
    stream_byte_t run[$];
    logic [LEN_W-1:0] clamped;
    logic [LEN_W-1:0] rem;
    logic [5:0] sz;
    logic [7:0] hdr;
    logic [7:0] cmp;
    logic done;
    if (!busy) begin
      clamped = (len > MAX_LEN) ? MAX_LEN : len;
      if (clamped == 0) return;
      msg_len = clamped;
      sent = '0;
      pkt_pos = '0;
      pkt_size = '0;
      pkt_sum = '0;
      busy = 1'b1;
    end
    if (pkt_pos == 0) begin
      rem = msg_len - sent;
      sz = (rem > FIRST_LIMIT) ? FULL_PKT : rem[5:0];
      if (msg_len > FIRST_LIMIT && sent == 0) begin
        hdr = {TYPE_FIRST, sz};
      end else if (rem > CONT_LIMIT && sent != 0) begin
        hdr = {TYPE_CONT, sz};
      end else begin
        hdr = {TYPE_LAST, sz};
      end
      cmp = 8'h00 - hdr;
      run.push_back('{b: cmp, kind: KIND_COMP, done: 1'b0, last: 1'b0});
      run.push_back('{b: hdr, kind: KIND_HDR, done: 1'b0, last: 1'b0});
      pkt_size = sz;
      pkt_sum = '0;
    end
    run.push_back('{b: d, kind: KIND_DATA, done: 1'b0, last: 1'b0});
    pkt_sum = pkt_sum + d;
    pkt_pos = pkt_pos + 6'd1;
    sent = sent + LEN_W'(1);
    if (pkt_pos >= pkt_size) begin
      done = (sent >= msg_len);
      run.push_back('{b: pkt_sum, kind: KIND_CKSUM, done: done, last: 1'b0});
      pkt_pos = '0;
      if (done) busy = 1'b0;
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] d, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_message_length <= LEN_W'($urandom);
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= d;
    in_message_length <= len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    segment_byte(d, len);
    @(negedge clk);
  endtask

  // length field is only read on the first byte; later ones carry noise
  task automatic send_message(input logic [LEN_W-1:0] len_field, input int unsigned nbytes);
    send_byte(8'($urandom), len_field);
    for (int unsigned i = 1; i < nbytes; i++) send_byte(8'($urandom), LEN_W'($urandom));
    payload_items += nbytes;
    messages++;
  endtask

  task automatic send_dropped(input logic [7:0] d);
    send_byte(d, '0);
    dropped_items++;
  endtask

  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin : check_stream
    stream_byte_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h kind %0d", out_byte, out_byte_kind));
      end else begin
        want = expected_bytes.pop_front();
        checked++;
        if (out_byte !== want.b)
          report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.b));
        if (out_byte_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_byte_kind, want.kind));
        if (out_message_done !== want.done)
          report_mismatch($sformatf("message_done %b, want %b", out_message_done, want.done));
        if (out_run_last !== want.last)
          report_mismatch($sformatf("run_last %b, want %b", out_run_last, want.last));
      end
    end
  end

  task automatic test_length_boundaries();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_dropped(8'hFF);
    send_byte(8'hFF, LEN_W'(1));
    payload_items++;
    messages++;
    send_dropped(8'h00);
    send_byte(8'h00, LEN_W'(2));
    send_byte(8'hFF, LEN_W'(0));
    payload_items += 2;
    messages++;
    // a lone 61-byte message is typed first yet still completes
    send_message(LEN_W'(61), 61);
  endtask

  task automatic test_random_messages();
    int idle_set[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{14, 14}};
    int phase_items;
    int pick;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p][0];
      pop_stall_pct = idle_set[p][1];
      phase_items = 0;
      while (phase_items < 6) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          send_dropped(8'($urandom));
        end else begin
          pick = $urandom_range(1, 12);
          send_message(LEN_W'(pick), pick);
          phase_items += pick;
        end
      end
    end
  endtask

  // saturated length keeps the message long: a first packet, then a
  // continue packet opens; the message is left open at the end of the run
  task automatic test_oversized_length();
    send_idle_pct = 14;
    pop_stall_pct = 14;
    send_byte(8'($urandom), LEN_W'(MAX_MESSAGE_BYTES + 5));
    for (int i = 1; i < 62; i++) send_byte(8'($urandom), LEN_W'($urandom));
    payload_items += 62;
  endtask

  initial begin
    int guard;
    clear_segmenter();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_length_boundaries();
    test_random_messages();
    test_oversized_length();

    in_push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    guard = 0;
    while (expected_bytes.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
    repeat (16) @(posedge clk);

    $display("covered %0d whole messages and one oversized open one under four stall mixes",
             messages);
    $display("%0d payload items, %0d zero-length items, %0d stream bytes checked",
             payload_items, dropped_items, checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rps_pkg.sv
sv/rps_front.sv
sv/rps_queue.sv
sv/rps_back.sv
sv/report_packet_segmenter.sv
test/report_packet_segmenter_test.sv
